// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the auto-repeat block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define BAR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define BAR_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BAR_ASSERT(lbl, clk, rst_n, prop, msg)
`define BAR_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- src/bar_pkg.sv -----
// Package with types, constants and the priority pick for the auto-repeat block.
`timescale 1ns / 1ps
package bar_pkg;

  localparam int unsigned PressedW   = 10;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned ActionW    = 4;
  localparam int unsigned KeyIdxW    = 4;
  localparam int unsigned KeyVecW    = 1 << KeyIdxW;
  localparam int unsigned NumKeysDef = 10;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;

  localparam logic [TimeW-1:0] InitialDelayRst = TimeW'(21428 / 2);
  localparam logic [TimeW-1:0] RepeatDelayRst  = TimeW'(21428 / 20);

  typedef enum logic [0:0] {
    REG_INITIAL_DELAY = 1'b0,
    REG_REPEAT_DELAY  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_INITIAL = 2'd1,
    MODE_REPEAT  = 2'd2
  } repeat_mode_e;

  typedef struct packed {
    logic [TimeW-1:0] initial_delay;
    logic [TimeW-1:0] repeat_delay;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [ActionW-1:0] action;
  } result_t;

  typedef struct packed {
    logic               found;
    logic [KeyIdxW-1:0] idx;
  } pick_t;

  // Lowest set bit wins.
  function automatic pick_t first_key(input logic [KeyVecW-1:0] keys);
    pick_t res;
    res = '0;
    for (int i = KeyVecW - 1; i >= 0; i--) begin
      if (keys[i]) begin
        res.found = 1'b1;
        res.idx   = KeyIdxW'(i);
      end
    end
    return res;
  endfunction

endpackage

// ----- src/button_auto_repeat.sv -----
// Top level of the typematic auto-repeat block for a small key pad.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each request is one poll of the pressed-key vector with the current tick count, and
// gives exactly one action (0 for none, else 1 plus the index of the reported key). The
// block takes one poll per clock cycle while the result buffer has room. A poll waits in the input
// register, where the priority pick and the elapsed-time compare update the repeat state.
// Its action is then written into a two-entry result buffer and offered from there. When
// the receiver stalls, two actions wait in the buffer and a third poll waits in the input
// register before the input ready drops. The delay registers (initial delay at byte
// address 0, repeat delay at 4) should be written only while no poll is in flight.
module button_auto_repeat #(
  parameter int unsigned NUM_KEYS = bar_pkg::NumKeysDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bar_pkg::AddrW-1:0]     paddr,
  input  logic [bar_pkg::DataW-1:0]     pwdata,
  output logic [bar_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bar_pkg::PressedW-1:0]  pressed_keys_i,
  input  logic [bar_pkg::TimeW-1:0]     time_now_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bar_pkg::ActionW-1:0]   action_o
);

  bar_pkg::cfg_t    cfg;
  bar_pkg::result_t res;
  logic             res_full;

  bar_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bar_core #(
    .NUM_KEYS (NUM_KEYS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pressed_keys_i (pressed_keys_i),
    .time_now_i     (time_now_i),
    .res_full_i     (res_full),
    .res_o          (res)
  );

  bar_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .full_o      (res_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .action_o    (action_o)
  );

  // A result must never be pushed into a full buffer.
  `BAR_NEVER(a_no_overflow, clk_i, rst_ni, res.valid && res_full, "result buffer overflow")
  // A reported action never names a key beyond the configured count.
  `BAR_ASSERT(a_action_range, clk_i, rst_ni, out_valid_o |-> ({1'b0, action_o} <= (bar_pkg::ActionW + 1)'(NUM_KEYS)), "action out of range")
  // A poll that stalls because the buffer is full is held until the buffer drains.
  `BAR_ASSERT(a_stall_hold, clk_i, rst_ni, (!in_ready_o && !out_ready_i) |=> !in_ready_o, "poll stage released without a drain")

endmodule

// ----- src/bar_cfg_regs.sv -----
// Delay registers behind the APB-style configuration port.
`timescale 1ns / 1ps
module bar_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bar_pkg::AddrW-1:0]   paddr,
  input  logic [bar_pkg::DataW-1:0]   pwdata,
  output logic [bar_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output bar_pkg::cfg_t               cfg_o
);

  bar_pkg::cfg_t     cfg_q, cfg_d;
  bar_pkg::reg_idx_e sel;
  logic              wr_en;

  assign pready = 1'b1;
  assign sel    = bar_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        bar_pkg::REG_INITIAL_DELAY: cfg_d.initial_delay = pwdata;
        bar_pkg::REG_REPEAT_DELAY:  cfg_d.repeat_delay  = pwdata;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      bar_pkg::REG_INITIAL_DELAY: prdata = cfg_q.initial_delay;
      bar_pkg::REG_REPEAT_DELAY:  prdata = cfg_q.repeat_delay;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_delay <= bar_pkg::InitialDelayRst;
      cfg_q.repeat_delay  <= bar_pkg::RepeatDelayRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/bar_core.sv -----
// Poll register, repeat state and the key pick that turns one poll into an action.
`timescale 1ns / 1ps
module bar_core #(
  parameter int unsigned NUM_KEYS = bar_pkg::NumKeysDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bar_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bar_pkg::PressedW-1:0]  pressed_keys_i,
  input  logic [bar_pkg::TimeW-1:0]     time_now_i,
  input  logic                          res_full_i,
  output bar_pkg::result_t              res_o
);

  localparam int unsigned KW = bar_pkg::KeyIdxW;
  localparam int unsigned VW = bar_pkg::KeyVecW;
  localparam int unsigned TW = bar_pkg::TimeW;

  // Poll register.
  logic                         poll_valid_q, poll_valid_d;
  logic [bar_pkg::PressedW-1:0] keys_q;
  logic [TW-1:0]                time_q;

  // Repeat state.
  bar_pkg::repeat_mode_e mode_q, mode_d;
  logic [KW-1:0]         held_q, held_d;
  logic [TW-1:0]         since_q, since_d;

  logic          in_acc;
  logic          adv;
  logic [VW-1:0] keys;
  logic [VW-1:0] avail;
  logic [VW-1:0] held_bit;
  logic          held_in_range;
  logic          still;
  logic          elapsed;
  logic [TW-1:0] limit;
  bar_pkg::pick_t pick;
  logic [bar_pkg::ActionW-1:0] action;

  assign adv        = poll_valid_q && !res_full_i;
  assign in_ready_o = !poll_valid_q || !res_full_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Keys at or above NUM_KEYS are ignored.
  for (genvar g = 0; g < VW; g++) begin : g_keys
    if (g < NUM_KEYS && g < bar_pkg::PressedW) begin : g_on
      assign keys[g] = keys_q[g];
    end else begin : g_off
      assign keys[g] = 1'b0;
    end
  end

  assign held_in_range = {1'b0, held_q} < (KW + 1)'(NUM_KEYS);
  assign still    = (mode_q != bar_pkg::MODE_IDLE) && held_in_range && keys[held_q];
  assign limit    = (mode_q == bar_pkg::MODE_INITIAL) ? cfg_i.initial_delay
                                                      : cfg_i.repeat_delay;
  assign elapsed  = (time_q - since_q) >= limit;
  assign held_bit = VW'(1) << held_q;
  assign avail    = (still && !elapsed) ? (keys & ~held_bit) : keys;
  assign pick     = bar_pkg::first_key(avail);

  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    since_d = since_q;
    action  = '0;
    if (adv) begin
      if (pick.found) begin
        held_d  = pick.idx;
        since_d = time_q;
        action  = bar_pkg::ActionW'({1'b0, pick.idx} + (KW + 1)'(1));
        if (still && pick.idx == held_q) begin
          mode_d = bar_pkg::MODE_REPEAT;
        end else begin
          mode_d = bar_pkg::MODE_INITIAL;
        end
      end else if (!still || elapsed) begin
        // A released key, or an elapsed delay with nothing left, drops to idle.
        mode_d = bar_pkg::MODE_IDLE;
      end
    end
  end

  always_comb begin
    poll_valid_d = poll_valid_q;
    if (in_acc) begin
      poll_valid_d = 1'b1;
    end else if (adv) begin
      poll_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_valid_q <= 1'b0;
      mode_q       <= bar_pkg::MODE_IDLE;
      held_q       <= '0;
      since_q      <= '0;
    end else begin
      poll_valid_q <= poll_valid_d;
      mode_q       <= mode_d;
      held_q       <= held_d;
      since_q      <= since_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      keys_q <= pressed_keys_i;
      time_q <= time_now_i;
    end
  end

  assign res_o.valid  = adv;
  assign res_o.action = action;

endmodule

// ----- src/bar_out_fifo.sv -----
// Two-entry result buffer so a waiting result does not stall new polls.
`timescale 1ns / 1ps
module bar_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bar_pkg::result_t             res_i,
  output logic                         full_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bar_pkg::ActionW-1:0]  action_o
);

  logic [bar_pkg::ActionW-1:0] mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign out_valid_o = count_q != 2'd0;
  assign full_o      = count_q == 2'd2;
  assign pop         = out_valid_o && out_ready_i;
  assign action_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = res_i.valid ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(res_i.valid) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      mem_q[wr_ptr_q] <= res_i.action;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the typematic auto-repeat block of the key pad.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [bar_pkg::PressedW-1:0] keys;
    logic [bar_pkg::TimeW-1:0]    now;
  } poll_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         psel           = 1'b0;
  logic                         penable        = 1'b0;
  logic                         pwrite         = 1'b0;
  logic [bar_pkg::AddrW-1:0]    paddr          = '0;
  logic [bar_pkg::DataW-1:0]    pwdata         = '0;
  logic [bar_pkg::DataW-1:0]    prdata;
  logic                         pready;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic [bar_pkg::PressedW-1:0] pressed_keys_i = '0;
  logic [bar_pkg::TimeW-1:0]    time_now_i     = '0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  logic [bar_pkg::ActionW-1:0]  action_o;

  button_auto_repeat dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pressed_keys_i(pressed_keys_i),
    .time_now_i    (time_now_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted state of the key pad and its delay registers.
  bar_pkg::repeat_mode_e       pad_mode       = bar_pkg::MODE_IDLE;
  logic [bar_pkg::KeyIdxW-1:0] pad_held_key   = '0;
  logic [bar_pkg::TimeW-1:0]   pad_held_since = '0;
  logic [bar_pkg::TimeW-1:0]   pad_init_delay = bar_pkg::InitialDelayRst;
  logic [bar_pkg::TimeW-1:0]   pad_rep_delay  = bar_pkg::RepeatDelayRst;

  poll_t                       pending_polls[$];
  logic [bar_pkg::ActionW-1:0] expected_actions[$];
  logic [bar_pkg::TimeW-1:0]   tick           = '0;
  bit                          burst          = 1'b0;
  int                          mismatches     = 0;
  int                          actions_seen   = 0;
  int                          send_gap       = 0;
  int                          recv_gap       = 0;
  int                          long_hold      = 0;

  function automatic int lowest_key(input logic [bar_pkg::PressedW-1:0] keys);
    for (int i = 0; i < bar_pkg::NumKeysDef; i++) begin
      if (keys[i]) return i;
    end
    return -1;
  endfunction

  // Advances the predicted state by one poll and returns the reported action.
  function automatic logic [bar_pkg::ActionW-1:0] typematic_action(
      input logic [bar_pkg::PressedW-1:0] keys,
      input logic [bar_pkg::TimeW-1:0]    now);
    logic [bar_pkg::PressedW-1:0] avail;
    logic [bar_pkg::TimeW-1:0]    limit;
    logic [bar_pkg::TimeW-1:0]    elapsed_ticks;
    logic                         elapsed;
    logic [bar_pkg::ActionW-1:0]  act;
    int                           k;
    act = '0;
    if (pad_mode != bar_pkg::MODE_IDLE) begin
      if (!(pad_held_key < bar_pkg::NumKeysDef && keys[pad_held_key])) begin
        pad_mode = bar_pkg::MODE_IDLE;
      end
    end
    if (pad_mode == bar_pkg::MODE_IDLE) begin
      k = lowest_key(keys);
      if (k >= 0) begin
        pad_mode       = bar_pkg::MODE_INITIAL;
        pad_held_since = now;
        pad_held_key   = bar_pkg::KeyIdxW'(k);
        act            = bar_pkg::ActionW'(k + 1);
      end
    end else begin
      limit         = (pad_mode == bar_pkg::MODE_INITIAL) ? pad_init_delay : pad_rep_delay;
      elapsed_ticks = now - pad_held_since;
      elapsed       = elapsed_ticks >= limit;
      avail         = keys;
      // The held key stays hidden until its delay has run out.
      if (!elapsed) avail[pad_held_key] = 1'b0;
      k = lowest_key(avail);
      if (k >= 0) begin
        pad_mode       = (bar_pkg::KeyIdxW'(k) == pad_held_key) ? bar_pkg::MODE_REPEAT
                                                                : bar_pkg::MODE_INITIAL;
        pad_held_since = now;
        pad_held_key   = bar_pkg::KeyIdxW'(k);
        act            = bar_pkg::ActionW'(k + 1);
      end else if (elapsed) begin
        pad_mode = bar_pkg::MODE_IDLE;
      end
    end
    return act;
  endfunction

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    poll_t p;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_actions.push_back(typematic_action(pressed_keys_i, time_now_i));
        send_gap = draw_gap();
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_polls.size() > 0) begin
          p = pending_polls.pop_front();
          in_valid_i     <= 1'b1;
          pressed_keys_i <= p.keys;
          time_now_i     <= p.now;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor; once in the run it stops taking results long enough to back up the block.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [bar_pkg::ActionW-1:0] exp_action;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_actions.size() == 0) begin
          $error("action: expected none, actual %0d", action_o);
          mismatches++;
        end else begin
          exp_action = expected_actions.pop_front();
          if (action_o !== exp_action) begin
            $error("action: expected %0d, actual %0d", exp_action, action_o);
            mismatches++;
          end
        end
        actions_seen++;
        recv_gap = draw_gap();
        if (actions_seen == 420) long_hold = 300;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_poll(input logic [bar_pkg::PressedW-1:0] keys,
                           input logic [bar_pkg::TimeW-1:0]    now);
    pending_polls.push_back(poll_t'{keys, now});
  endtask

  task automatic write_delay(input bar_pkg::reg_idx_e idx,
                             input logic [bar_pkg::TimeW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bar_pkg::AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bar_pkg::REG_INITIAL_DELAY) pad_init_delay = val;
    else pad_rep_delay = val;
  endtask

  task automatic drain();
    while (pending_polls.size() != 0 || in_valid_i || expected_actions.size() != 0)
      @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Mostly a key held across many polls with time moving on, plus some noise and releases.
  task automatic push_key_runs(input int n, input logic [bar_pkg::TimeW-1:0] max_step);
    int                           left;
    int                           run;
    logic [bar_pkg::PressedW-1:0] base;
    logic [bar_pkg::PressedW-1:0] keys;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        tick = $urandom;
        push_poll(bar_pkg::PressedW'($urandom), tick);
        left--;
      end else begin
        base = bar_pkg::PressedW'(1) << $urandom_range(0, bar_pkg::NumKeysDef - 1);
        run  = $urandom_range(1, 20);
        for (int i = 0; i < run && left > 0; i++) begin
          tick += $urandom_range(0, max_step);
          keys = base;
          if ($urandom_range(0, 5) == 0) keys |= bar_pkg::PressedW'($urandom);
          if ($urandom_range(0, 15) == 0) keys = '0;
          push_poll(keys, tick);
          left--;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed polls under the reset delays.
    push_poll('0, '0);
    push_poll('1, 32'd0);
    push_poll('1, 32'd5);
    push_poll(10'h002, 32'd10);
    push_poll(10'h002, 32'd10724);
    push_poll(10'h002, 32'd11794);
    push_poll(10'h002, 32'd11795);
    push_poll('0, 32'd11800);
    for (int i = 0; i < bar_pkg::NumKeysDef; i++) begin
      push_poll(bar_pkg::PressedW'(1) << i, 32'd20000);
    end
    push_poll(10'h200, 32'hFFFF_FF00);
    push_poll(10'h200, 32'hFFFF_FFFF);
    push_poll(10'h200, 32'h0000_29DA);
    drain();
    push_key_runs(100, 32'd4000);
    drain();

    burst = 1'b1;
    write_delay(bar_pkg::REG_INITIAL_DELAY, '0);
    write_delay(bar_pkg::REG_REPEAT_DELAY, '0);
    push_key_runs(80, 32'd3);
    drain();

    burst = 1'b0;
    write_delay(bar_pkg::REG_INITIAL_DELAY, '1);
    write_delay(bar_pkg::REG_REPEAT_DELAY, '1);
    // A time one tick short of the report is a full wrap, the only way to reach the delay.
    push_poll(10'h001, 32'd5);
    push_poll(10'h001, 32'd4);
    push_poll(10'h001, 32'd4);
    push_key_runs(60, '1);
    drain();

    write_delay(bar_pkg::REG_INITIAL_DELAY, 32'd40);
    write_delay(bar_pkg::REG_REPEAT_DELAY, 32'd8);
    push_key_runs(120, 32'd12);
    drain();

    burst = 1'b1;
    write_delay(bar_pkg::REG_INITIAL_DELAY, bar_pkg::TimeW'($urandom_range(0, 200)));
    write_delay(bar_pkg::REG_REPEAT_DELAY, bar_pkg::TimeW'($urandom_range(0, 200)));
    push_key_runs(100, 32'd60);
    drain();

    burst = 1'b0;
    write_delay(bar_pkg::REG_INITIAL_DELAY, $urandom);
    write_delay(bar_pkg::REG_REPEAT_DELAY, $urandom);
    push_key_runs(40, '1);
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- button_auto_repeat.f -----
+incdir+src
src/bar_pkg.sv
src/bar_cfg_regs.sv
src/bar_core.sv
src/bar_out_fifo.sv
src/button_auto_repeat.sv
tb/tb_top.sv
